### rtl/pam_pkg.sv
// Package for the polarization angle mean block: types, CORDIC table, codes.
`timescale 1ns / 1ps
package pam_pkg;

  localparam int TAB_LEN  = 24;
  localparam int ANG_W    = 32;
  localparam int CORD_W   = 42;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 23;
  localparam int ANGLE_W  = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_POS_I0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_I45  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_I90  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_I135 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_HALF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H    = 3'd6;

  localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam longint INV_GAIN_Q30 = 64'd652032875;
  localparam logic [14:0] CENTI_HALF = 15'd18000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VEC_START, ST_VEC_WAIT, ST_ROT_START, ST_ROT_WAIT,
    ST_ACCUM, ST_FIN_START, ST_FIN_WAIT, ST_SCALE
  } state_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctl_t;

  function automatic logic [ANG_W-1:0] atan_lookup(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/pam_cordic.sv
// Shared iterative CORDIC: vectoring (angle of x,y) or rotation (unit cos/sin).
`timescale 1ns / 1ps
module pam_cordic #(
  parameter int CORDIC_ITERS = 16,
  parameter int FRAC_BITS    = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pam_pkg::cordic_ctl_t             ctl,
  input  logic signed [pam_pkg::CORD_W-1:0] x_in,
  input  logic signed [pam_pkg::CORD_W-1:0] y_in,
  input  logic [pam_pkg::ANG_W-1:0]        z_in,
  output logic                             done,
  output logic signed [pam_pkg::CORD_W-1:0] x_out,
  output logic signed [pam_pkg::CORD_W-1:0] y_out,
  output logic [pam_pkg::ANG_W-1:0]        z_out
);
  import pam_pkg::*;

  localparam int ITERS = (CORDIC_ITERS < TAB_LEN) ? CORDIC_ITERS : TAB_LEN;
  localparam longint X0 = (INV_GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [ANG_W-1:0] z_r, z_nxt;
  logic [4:0] it_r, it_nxt;
  logic busy_r, busy_nxt, rot_r, rot_nxt, flip_r, flip_nxt, done_r, done_nxt;
  logic signed [CORD_W-1:0] xs, ys;
  logic dir_pos;
  logic [ANG_W-1:0] tab;

  assign xs  = x_r >>> it_r;
  assign ys  = y_r >>> it_r;
  assign tab = atan_lookup(it_r);
  assign dir_pos = rot_r ? ~z_r[ANG_W-1] : ~y_r[CORD_W-1];

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    busy_nxt = busy_r; rot_nxt = rot_r; flip_nxt = flip_r; done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1; it_nxt = '0; rot_nxt = ctl.rotate; flip_nxt = 1'b0;
      if (ctl.rotate) begin
        // fold angles outside [-90,90) by a half turn
        x_nxt = CORD_W'(X0); y_nxt = '0; z_nxt = z_in;
        if (z_in >= QUARTER_TURN && z_in < HALF_TURN + QUARTER_TURN) begin
          flip_nxt = 1'b1; z_nxt = z_in - HALF_TURN;
        end
      end else if (x_in < 0) begin
        x_nxt = -x_in; y_nxt = -y_in; z_nxt = HALF_TURN;
      end else begin
        x_nxt = x_in; y_nxt = y_in; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (rot_r == dir_pos) begin
        x_nxt = x_r - ys; y_nxt = y_r + xs;
      end else begin
        x_nxt = x_r + ys; y_nxt = y_r - xs;
      end
      if (dir_pos) z_nxt = rot_r ? z_r - tab : z_r + tab;
      else         z_nxt = rot_r ? z_r + tab : z_r - tab;
      it_nxt = it_r + 5'd1;
      if (it_r == 5'(ITERS - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt;
    rot_r <= rot_nxt; flip_r <= flip_nxt;
  end

  assign done  = done_r;
  assign x_out = flip_r ? -x_r : x_r;
  assign y_out = flip_r ? -y_r : y_r;
  assign z_out = z_r;
endmodule

### rtl/polarization_angle_mean.sv
// Top level: quad windowing, CORDIC sequencing, saturating sums, frame result.
`timescale 1ns / 1ps
// A counted quad runs a vectoring pass and a rotation pass on the CORDIC, a zero
// difference skips the vectoring pass; a quad outside the window skips both; the last
// quad adds a final vectoring pass and angle scaling. The shared CORDIC serves every
// pass; one quad is in work at a time. The result sits in an output register until
// taken; a later frame result waits in scaling while that register is full.
// Reset (rst_n, synchronous) restores register defaults and clears the sums.
module polarization_angle_mean #(
  parameter int PIXEL_BITS   = 16,
  parameter int MAX_DIM      = 4096,
  parameter int CORDIC_ITERS = 16,
  parameter int FRAC_BITS    = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pix_top_left[15:0], pix_top_right[31:16], pix_bottom_left[47:32],
  // pix_bottom_right[63:48], quad_row[75:64], quad_col[87:76]
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // angle_centideg[14:0], quad_count[37:15]
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pam_pkg::CFG_DAT_W-1:0] cfg_data
);
  import pam_pkg::*;

  localparam logic [13:0] MAXD = 14'(MAX_DIM);
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic [1:0] p0_r, p45_r, p90_r, p135_r;
  logic [11:0] roi_r;
  logic [12:0] w_r, h_r;

  state_t st_r, st_nxt;
  logic signed [SUM_W-1:0] sc_r, sc_nxt, ss_r, ss_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic last_r, last_nxt;
  logic signed [16:0] dc_r, dc_nxt, ds_r, ds_nxt;
  logic [ANG_W-1:0] z_r, z_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic ov_r, ov_nxt;
  logic [39:0] out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  cordic_ctl_t ctl;
  logic signed [CORD_W-1:0] cx_in, cy_in, cx, cy;
  logic [ANG_W-1:0] cz;
  logic cdone;

  pam_cordic #(.CORDIC_ITERS(CORDIC_ITERS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk, .rst_n, .ctl, .x_in(cx_in), .y_in(cy_in), .z_in(z_r),
    .done(cdone), .x_out(cx), .y_out(cy), .z_out(cz)
  );

  function automatic logic in_win(input logic [11:0] p, input logic [12:0] dim,
                                  input logic [11:0] roi);
    logic [13:0] d, half, st, en, q;
    d    = ({1'b0, dim} > MAXD) ? MAXD : {1'b0, dim};
    half = d >> 1;
    st = '0; en = d;
    if (roi != 0) begin
      st = (half > {2'b0, roi}) ? half - {2'b0, roi} : '0;
      en = (half + {2'b0, roi} > d) ? d : half + {2'b0, roi};
    end
    q = {2'b0, p};
    return (q >= st) && (q < en) && (q + 14'd2 <= d) && (q[0] == st[0]);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [CORD_W-1:0] b);
    logic signed [CORD_W:0] v;
    v = {{(CORD_W-SUM_W+1){a[SUM_W-1]}}, a} + {b[CORD_W-1], b};
    if (v > $signed({{(CORD_W-SUM_W+1){1'b0}}, SUM_MAX})) return SUM_MAX;
    if (v < $signed({{(CORD_W-SUM_W+1){1'b1}}, SUM_MIN})) return SUM_MIN;
    return v[SUM_W-1:0];
  endfunction

  logic [PIXEL_BITS-1:0] pix [4];
  always_comb begin
    for (int k = 0; k < 4; k++) pix[k] = in_tdata[16*k +: PIXEL_BITS];
  end

  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  always_comb begin
    st_nxt = st_r; sc_nxt = sc_r; ss_nxt = ss_r; cnt_nxt = cnt_r; last_nxt = last_r;
    dc_nxt = dc_r; ds_nxt = ds_r; z_nxt = z_r; prod_nxt = prod_r; ov_nxt = ov_r;
    out_nxt = out_r;
    out_v_nxt = out_v_r & ~out_tready;
    ctl = '0; cx_in = CORD_W'(dc_r); cy_in = CORD_W'(ds_r);
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        last_nxt = in_tlast;
        dc_nxt = $signed({1'b0, 16'(pix[p0_r])}) - $signed({1'b0, 16'(pix[p90_r])});
        ds_nxt = $signed({1'b0, 16'(pix[p45_r])}) - $signed({1'b0, 16'(pix[p135_r])});
        if (in_win(in_tdata[75:64], h_r, roi_r) && in_win(in_tdata[87:76], w_r, roi_r))
          st_nxt = ST_VEC_START;
        else st_nxt = in_tlast ? ST_FIN_START : ST_IDLE;
      end
      ST_VEC_START: begin
        if (dc_r == 0 && ds_r == 0) begin
          z_nxt = '0; st_nxt = ST_ROT_START;
        end else begin
          ctl.start = 1'b1; st_nxt = ST_VEC_WAIT;
        end
      end
      ST_VEC_WAIT: if (cdone) begin z_nxt = cz; st_nxt = ST_ROT_START; end
      ST_ROT_START: begin ctl.start = 1'b1; ctl.rotate = 1'b1; st_nxt = ST_ROT_WAIT; end
      ST_ROT_WAIT: if (cdone) st_nxt = ST_ACCUM;
      ST_ACCUM: begin
        sc_nxt = sat_add(sc_r, cx);
        ss_nxt = sat_add(ss_r, cy);
        if (cnt_r != {CNT_W{1'b1}}) cnt_nxt = cnt_r + 1'b1;
        st_nxt = last_r ? ST_FIN_START : ST_IDLE;
      end
      ST_FIN_START: begin
        cx_in = CORD_W'(sc_r); cy_in = CORD_W'(ss_r);
        if (sc_r == 0 && ss_r == 0) begin
          z_nxt = '0; st_nxt = ST_SCALE;
        end else begin
          ctl.start = 1'b1; st_nxt = ST_FIN_WAIT;
        end
      end
      ST_FIN_WAIT: if (cdone) begin z_nxt = cz; st_nxt = ST_SCALE; end
      ST_SCALE: begin
        // z * 18000 / 2^32 rounded; one 32x15 product
        prod_nxt = 48'(z_r) * 48'(CENTI_HALF) + 48'(HALF_TURN);
        ov_nxt = 1'b1;
        // hold while the previous result still waits in the output register
        if (ov_r && (!out_v_r || out_tready)) begin
          out_nxt[14:0] = (prod_r[46:32] >= CENTI_HALF) ? '0 : prod_r[46:32];
          out_nxt[37:15] = cnt_r;
          out_nxt[39:38] = '0;
          out_v_nxt = 1'b1;
          sc_nxt = '0; ss_nxt = '0; cnt_nxt = '0; ov_nxt = 1'b0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; sc_r <= '0; ss_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
      out_v_r <= 1'b0;
      p0_r <= 2'd1; p45_r <= 2'd3; p90_r <= 2'd2; p135_r <= 2'd0;
      roi_r <= '0; w_r <= 13'd2448; h_r <= 13'd2048;
    end else begin
      st_r <= st_nxt; sc_r <= sc_nxt; ss_r <= ss_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_POS_I0:   p0_r   <= cfg_data[1:0];
          REG_POS_I45:  p45_r  <= cfg_data[1:0];
          REG_POS_I90:  p90_r  <= cfg_data[1:0];
          REG_POS_I135: p135_r <= cfg_data[1:0];
          REG_ROI_HALF: roi_r  <= cfg_data[11:0];
          REG_IMG_W:    w_r    <= cfg_data;
          REG_IMG_H:    h_r    <= cfg_data;
          default: ;
        endcase
      end
    end
    last_r <= last_nxt; dc_r <= dc_nxt; ds_r <= ds_nxt; z_r <= z_nxt;
    prod_r <= prod_nxt; out_r <= out_nxt;
  end
endmodule

### dv/polarization_angle_mean_test.sv
// Self-checking testbench for the polarization angle mean block.
`timescale 1ns / 1ps
module polarization_angle_mean_test;
  import pam_pkg::*;

  localparam int ITERS = 16;
  localparam int FRAC = 15;
  localparam longint SMAX = 64'sd549755813887;
  localparam longint SMIN = -64'sd549755813888;
  localparam int CMAX = 8388607;

  typedef struct packed {
    logic [14:0] angle;
    logic [22:0] count;
  } frame_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  polarization_angle_mean dut (.*);

  always #6 clk = ~clk;

  // Predicts frame results and holds them until the block delivers them.
  class angle_board;
    bit [1:0] p0, p45, p90, p135;
    int unsigned roi, wid, hgt;
    longint ssin, scos;
    int unsigned nq;
    frame_res_t pend[$];
    int errs;
    int frames;

    function void reset_state();
      p0 = 1; p45 = 3; p90 = 2; p135 = 0;
      roi = 0; wid = 2448; hgt = 2048;
      ssin = 0; scos = 0; nq = 0; errs = 0; frames = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
      case (idx)
        REG_POS_I0:   p0 = v[1:0];
        REG_POS_I45:  p45 = v[1:0];
        REG_POS_I90:  p90 = v[1:0];
        REG_POS_I135: p135 = v[1:0];
        REG_ROI_HALF: roi = v[11:0];
        REG_IMG_W:    wid = v;
        REG_IMG_H:    hgt = v;
        default: ;
      endcase
    endfunction

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function logic [31:0] heading(longint x, longint y);
      logic [31:0] z;
      longint xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < ITERS; i++) begin
        xs = shr(x, i); ys = shr(y, i);
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + atan_lookup(5'(i));
        end else begin
          x = x - ys; y = y + xs; z = z - atan_lookup(5'(i));
        end
      end
      return z;
    endfunction

    function void unit_vec(logic [31:0] z, output longint c, output longint s);
      longint x, y, r, xs, ys;
      bit flip;
      flip = 0;
      if (z >= QUARTER_TURN && z < 32'hC000_0000) begin
        flip = 1; z = z - HALF_TURN;
      end
      r = z[31] ? longint'(z) - 64'sd4294967296 : longint'(z);
      x = (INV_GAIN_Q30 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
        xs = shr(x, i); ys = shr(y, i);
        if (r >= 0) begin
          x = x - ys; y = y + xs; r = r - longint'(atan_lookup(5'(i)));
        end else begin
          x = x + ys; y = y - xs; r = r + longint'(atan_lookup(5'(i)));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint clamp_add(longint a, longint b);
      longint v;
      v = a + b;
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    function bit on_grid(longint q, int unsigned dim);
      longint d, st, en;
      d = dim > 4096 ? 4096 : dim;
      st = 0; en = d;
      if (roi > 0) begin
        st = d / 2 - longint'(roi); en = d / 2 + longint'(roi);
        if (st < 0) st = 0;
        if (en > d) en = d;
      end
      if (q < st || q >= en || q + 2 > d) return 0;
      return ((q - st) & 1) == 0;
    endfunction

    function void note_quad(logic [87:0] d, logic last);
      longint px[4];
      longint dc, ds, c, s;
      logic [31:0] z;
      logic [63:0] cd;
      frame_res_t r;
      for (int k = 0; k < 4; k++) px[k] = d[16*k +: 16];
      if (on_grid(d[75:64], hgt) && on_grid(d[87:76], wid)) begin
        dc = px[p0] - px[p90];
        ds = px[p45] - px[p135];
        unit_vec(heading(dc, ds), c, s);
        scos = clamp_add(scos, c);
        ssin = clamp_add(ssin, s);
        if (nq < CMAX) nq++;
      end
      if (!last) return;
      z = heading(scos, ssin);
      cd = (64'(z) * 64'd18000 + 64'(HALF_TURN)) >> 32;
      if (cd >= 18000) cd = 0;
      r.angle = cd[14:0];
      r.count = nq[22:0];
      pend.push_back(r);
      ssin = 0; scos = 0; nq = 0;
    endfunction

    function void check_frame(logic [39:0] d);
      frame_res_t got, want;
      got.angle = d[14:0];
      got.count = d[37:15];
      frames++;
      if (pend.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result angle=%0d count=%0d", got.angle, got.count);
        return;
      end
      want = pend.pop_front();
      if (got.angle !== want.angle || got.count !== want.count) begin
        errs++;
        if (errs <= 10)
          $display("frame %0d: expected angle=%0d count=%0d, got angle=%0d count=%0d",
                   frames, want.angle, want.count, got.angle, got.count);
      end
    endfunction
  endclass

  angle_board sb = new();
  bit calm = 0;       // last part of run: no idling
  int hold_cycles = 0; // long receiver hold-off
  int sent = 0;

  // result side: random stalls, one long hold
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 0;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_tready <= 0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // valid stays up after a transfer so the next quad can follow at once
  task automatic send_quad(logic [87:0] d, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tdata <= d;
    in_tlast <= last;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_quad(d, last);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [87:0] pack_quad(logic [63:0] px, int row, int col);
    return {col[11:0], row[11:0], px};
  endfunction

  function automatic logic [63:0] rand_px();
    return {$urandom(), $urandom()};
  endfunction

  // drop valid, drain and let the block settle before touching registers
  task automatic quiesce();
    in_tvalid <= 0;
    while (sb.pend.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // one small frame on the grid, with some off-grid noise
  task automatic run_frame(int n);
    int w, h, r, c;
    w = sb.wid > 4096 ? 4096 : sb.wid;
    h = sb.hgt > 4096 ? 4096 : sb.hgt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 4095); c = $urandom_range(0, 4095);
      end else begin
        r = $urandom_range(0, h / 2) * 2 + ($urandom_range(0, 7) == 0);
        c = $urandom_range(0, w / 2) * 2 + ($urandom_range(0, 7) == 0);
        if (r > 4095) r = 4095;
        if (c > 4095) c = 4095;
      end
      send_quad(pack_quad(rand_px(), r, c), i == n - 1);
    end
  endtask

  task automatic rand_config();
    write_cfg(REG_POS_I0, $urandom_range(0, 3));
    write_cfg(REG_POS_I45, $urandom_range(0, 3));
    write_cfg(REG_POS_I90, $urandom_range(0, 3));
    write_cfg(REG_POS_I135, $urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: write_cfg(REG_ROI_HALF, 0);
      1: write_cfg(REG_ROI_HALF, $urandom_range(1, 8));
      2: write_cfg(REG_ROI_HALF, 2048);
      default: write_cfg(REG_ROI_HALF, $urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 3))
      0: write_cfg(REG_IMG_W, $urandom_range(0, 3));
      1: write_cfg(REG_IMG_W, $urandom_range(4, 40));
      2: write_cfg(REG_IMG_W, 8191);
      default: write_cfg(REG_IMG_W, $urandom_range(0, 8191));
    endcase
    case ($urandom_range(0, 3))
      0: write_cfg(REG_IMG_H, $urandom_range(0, 3));
      1: write_cfg(REG_IMG_H, $urandom_range(4, 40));
      2: write_cfg(REG_IMG_H, 4096);
      default: write_cfg(REG_IMG_H, $urandom_range(0, 8191));
    endcase
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: defaults, extremes, zero vector, off-grid last
    send_quad(pack_quad(64'h0, 0, 0), 0);
    send_quad(pack_quad({4{16'hFFFF}}, 2, 2), 0);
    send_quad(pack_quad(64'h0000_FFFF_0000_FFFF, 4094, 4094), 0);
    send_quad(pack_quad(64'hFFFF_0000_FFFF_0000, 2046, 2446), 0);
    send_quad(pack_quad(64'h0, 1, 3), 1);
    send_quad(pack_quad(64'h0, 0, 0), 1); // zero-vector only frame
    send_quad(pack_quad(64'h1234_5678_9ABC_DEF0, 3, 3), 1); // empty frame
    quiesce();
    write_cfg(REG_POS_I0, 0); write_cfg(REG_POS_I45, 0);
    write_cfg(REG_POS_I90, 3); write_cfg(REG_POS_I135, 3);
    write_cfg(REG_ROI_HALF, 2048); write_cfg(REG_IMG_W, 2); write_cfg(REG_IMG_H, 8191);
    send_quad(pack_quad(64'hFFFF_0000_0000_0000, 0, 0), 0);
    send_quad(pack_quad(64'h0000_0000_0000_FFFF, 2046, 0), 1);
    quiesce();
    write_cfg(REG_IMG_W, 1); write_cfg(REG_ROI_HALF, 1); write_cfg(REG_IMG_H, 4);
    send_quad(pack_quad(64'hFFFF, 0, 0), 1);
    quiesce();

    // stall the receiver while frames pile up
    rand_config();
    hold_cycles = 2000;
    for (int f = 0; f < 8; f++) run_frame(2);
    quiesce();

    while (sent < 1900) begin
      if (sent > 1650) calm = 1;
      if ($urandom_range(0, 3) == 0) begin
        quiesce();
        rand_config();
      end
      run_frame($urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12));
    end

    quiesce();
    repeat (40) @(negedge clk);
    $display("Sent %0d quads over %0d frames with random register settings and stalls.",
             sent, sb.frames);
    if (sb.errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", sb.errs);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule
